// File: hdl/image_region_thread_split_macros.svh
// Assertion macros shared by the image region thread split RTL.
`ifndef IMAGE_REGION_THREAD_SPLIT_MACROS_SVH
`define IMAGE_REGION_THREAD_SPLIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/irts_pkg.sv
// Shared constants and types for the image region thread split block.
package irts_pkg;

  localparam int DEF_MAX_THREADS = 8;
  localparam int DEF_DIM_BITS    = 12;

  localparam int TC_FIELD_W  = 4;
  localparam int STRIDE_W    = 4;
  localparam int OUT_FIELD_W = 13;
  localparam int OUT_RAW_W   = 4 * OUT_FIELD_W;
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  // status from the serial divider back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/irts_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module irts_divider #(
  parameter int W = irts_pkg::DEF_DIM_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem,
  output irts_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     dvd_r, dvd_nxt;
  logic [W-1:0]     dvs_r;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             qbit;

  always_comb begin
    trial = {rem_r, dvd_r[W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? diff[W-1:0] : trial[W-1:0];
    dvd_nxt = {dvd_r[W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quot      = dvd_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hdl/image_region_thread_split.sv
// Splits an image into per-thread regions under a sequencer around one divider.
// All divisions run one at a time on the shared divider: height, width, then both by thread count.
// Each region then takes its own share division and an adjust step before out_tvalid rises;
// a further region starts only after the previous one is taken, and a new request only when idle.
// Synchronous active-low reset returns the sequencer to idle with no item pending.
`include "image_region_thread_split_macros.svh"

module image_region_thread_split #(
  parameter int MAX_THREADS = irts_pkg::DEF_MAX_THREADS,
  parameter int DIM_BITS    = irts_pkg::DEF_DIM_BITS,
  localparam int IN_RAW_W   = irts_pkg::TC_FIELD_W + 4 * DIM_BITS
                              + 2 * irts_pkg::STRIDE_W,
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // thread_count, image_height, image_width, row_offset, col_offset,
  // row_stride, col_stride (lowest bits first), zero padded
  input  logic [IN_DATA_W-1:0]            in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // top_row, left_col, row_count, col_count (lowest bits first), zero padded
  output logic [irts_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam int TC_W   = $clog2(MAX_THREADS + 1);
  localparam int THR_W  = (TC_W > irts_pkg::TC_FIELD_W) ? TC_W : irts_pkg::TC_FIELD_W;
  localparam int MAX_W  = (DIM_BITS > THR_W) ? DIM_BITS : THR_W;
  localparam int DIV_W  = MAX_W + 1;
  localparam int SUM_W  = DIM_BITS + 3;
  localparam int OFW    = irts_pkg::OUT_FIELD_W;
  localparam int SW     = irts_pkg::STRIDE_W;
  localparam int TCF    = irts_pkg::TC_FIELD_W;

  localparam int H_LO   = TCF;
  localparam int W_LO   = H_LO + DIM_BITS;
  localparam int RO_LO  = W_LO + DIM_BITS;
  localparam int CO_LO  = RO_LO + DIM_BITS;
  localparam int RS_LO  = CO_LO + DIM_BITS;
  localparam int CS_LO  = RS_LO + SW;

  typedef enum logic [3:0] {
    S_IDLE, S_DH, S_DW, S_MH, S_MW, S_START, S_SH, S_ADJ, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt, i_r, i_nxt;
  logic [DIM_BITS-1:0] hgt_r, hgt_nxt, wid_r, wid_nxt;
  logic [DIM_BITS-1:0] roff_r, roff_nxt, coff_r, coff_nxt;
  logic [SW-1:0]       rstr_r, rstr_nxt, cstr_r, cstr_nxt;
  logic [DIM_BITS-1:0] ah_r, ah_nxt, aw_r, aw_nxt, remain_r, remain_nxt;
  logic                mh_zero_r, mh_zero_nxt, by_h_r, by_h_nxt;
  logic [SUM_W-1:0]    pos_r, pos_nxt, sc_r, sc_nxt;
  logic                last_r, last_nxt;
  logic [OFW-1:0]      top_r, top_nxt, left_r, left_nxt;
  logic [OFW-1:0]      rows_r, rows_nxt, cols_r, cols_nxt;
  logic                out_valid_r, out_valid_nxt;

  // divider hookup
  logic                div_start;
  logic [DIV_W-1:0]    div_dvd, div_dvs, div_quot, div_rem;
  irts_pkg::div_stat_t div_stat;

  // unpacked request fields
  logic [THR_W-1:0]    tc_ext, tc_fix;
  logic [SW-1:0]       rs_in, cs_in, rs_fix, cs_fix;

  // region working values
  logic [SW-1:0]       stride;
  logic [DIM_BITS-1:0] size, offset;
  logic                odd;
  logic [DIM_BITS-1:0] share;
  logic [DIM_BITS-1:0] remain_left;
  logic [DIM_BITS+SW-1:0] prod;
  logic [SUM_W-1:0]    pos_off, adj;

  irts_divider #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_quot),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  always_comb begin
    tc_ext = THR_W'(in_tdata[TCF-1:0]);
    if (tc_ext == '0) begin
      tc_fix = THR_W'(1);
    end else if (tc_ext > THR_W'(MAX_THREADS)) begin
      tc_fix = THR_W'(MAX_THREADS);
    end else begin
      tc_fix = tc_ext;
    end
    rs_in  = in_tdata[RS_LO +: SW];
    cs_in  = in_tdata[CS_LO +: SW];
    rs_fix = (rs_in == '0) ? SW'(1) : rs_in;
    cs_fix = (cs_in == '0) ? SW'(1) : cs_in;
  end

  always_comb begin
    stride      = by_h_r ? rstr_r : cstr_r;
    size        = by_h_r ? hgt_r  : wid_r;
    offset      = by_h_r ? roff_r : coff_r;
    odd         = size[0];  // size modulo two
    share       = div_quot[DIM_BITS-1:0];
    remain_left = remain_r - share;
    prod        = share * stride;
    pos_off     = pos_r + SUM_W'(offset);
    // a share reaching past an odd size gives back the extra line
    if (odd && (pos_off + sc_r > SUM_W'(size))) begin
      adj = sc_r - 1'b1;
    end else begin
      adj = sc_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = thr_r;
    i_nxt         = i_r;
    hgt_nxt       = hgt_r;
    wid_nxt       = wid_r;
    roff_nxt      = roff_r;
    coff_nxt      = coff_r;
    rstr_nxt      = rstr_r;
    cstr_nxt      = cstr_r;
    ah_nxt        = ah_r;
    aw_nxt        = aw_r;
    remain_nxt    = remain_r;
    mh_zero_nxt   = mh_zero_r;
    by_h_nxt      = by_h_r;
    pos_nxt       = pos_r;
    sc_nxt        = sc_r;
    last_nxt      = last_r;
    top_nxt       = top_r;
    left_nxt      = left_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          thr_nxt   = tc_fix;
          hgt_nxt   = in_tdata[H_LO +: DIM_BITS];
          wid_nxt   = in_tdata[W_LO +: DIM_BITS];
          roff_nxt  = in_tdata[RO_LO +: DIM_BITS];
          coff_nxt  = in_tdata[CO_LO +: DIM_BITS];
          rstr_nxt  = rs_fix;
          cstr_nxt  = cs_fix;
          div_start = 1'b1;
          div_dvd   = DIV_W'(in_tdata[H_LO +: DIM_BITS]);
          div_dvs   = DIV_W'(rs_fix);
          state_nxt = S_DH;
        end
      end
      S_DH: begin
        if (div_stat.done) begin
          ah_nxt    = div_quot[DIM_BITS-1:0];
          div_start = 1'b1;
          div_dvd   = DIV_W'(wid_r);
          div_dvs   = DIV_W'(cstr_r);
          state_nxt = S_DW;
        end
      end
      S_DW: begin
        if (div_stat.done) begin
          aw_nxt    = div_quot[DIM_BITS-1:0];
          div_start = 1'b1;
          div_dvd   = DIV_W'(ah_r);
          div_dvs   = DIV_W'(thr_r);
          state_nxt = S_MH;
        end
      end
      S_MH: begin
        if (div_stat.done) begin
          mh_zero_nxt = (div_rem == '0);
          div_start   = 1'b1;
          div_dvd     = DIV_W'(aw_r);
          div_dvs     = DIV_W'(thr_r);
          state_nxt   = S_MW;
        end
      end
      S_MW: begin
        if (div_stat.done) begin
          if (mh_zero_r) begin
            by_h_nxt = 1'b1;
          end else if (div_rem == '0) begin
            by_h_nxt = 1'b0;
          end else begin
            by_h_nxt = (ah_r > aw_r);
          end
          remain_nxt = by_h_nxt ? ah_r : aw_r;
          i_nxt      = thr_r;
          pos_nxt    = '0;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        // an empty chosen dimension ends the request with no region
        if (remain_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(remain_r) + DIV_W'(i_r) - 1'b1;
          div_dvs   = DIV_W'(i_r);
          state_nxt = S_SH;
        end
      end
      S_SH: begin
        if (div_stat.done) begin
          remain_nxt = remain_left;
          i_nxt      = i_r - 1'b1;
          last_nxt   = (remain_left == '0);
          sc_nxt     = SUM_W'(prod) + SUM_W'(odd && (remain_left == '0));
          state_nxt  = S_ADJ;
        end
      end
      S_ADJ: begin
        top_nxt       = by_h_r ? OFW'(pos_off) : '0;
        left_nxt      = by_h_r ? '0 : OFW'(pos_off);
        rows_nxt      = by_h_r ? OFW'(adj) : OFW'(hgt_r);
        cols_nxt      = by_h_r ? OFW'(wid_r) : OFW'(adj);
        pos_nxt       = pos_r + adj;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = last_r ? S_IDLE : S_START;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    thr_r     <= thr_nxt;
    i_r       <= i_nxt;
    hgt_r     <= hgt_nxt;
    wid_r     <= wid_nxt;
    roff_r    <= roff_nxt;
    coff_r    <= coff_nxt;
    rstr_r    <= rstr_nxt;
    cstr_r    <= cstr_nxt;
    ah_r      <= ah_nxt;
    aw_r      <= aw_nxt;
    remain_r  <= remain_nxt;
    mh_zero_r <= mh_zero_nxt;
    by_h_r    <= by_h_nxt;
    pos_r     <= pos_nxt;
    sc_r      <= sc_nxt;
    last_r    <= last_nxt;
    top_r     <= top_nxt;
    left_r    <= left_nxt;
    rows_r    <= rows_nxt;
    cols_r    <= cols_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {(irts_pkg::OUT_DATA_W - irts_pkg::OUT_RAW_W)'(0),
                       cols_r, rows_r, left_r, top_r};

  `IRTS_ASSERT_NOW(a_no_in_while_out, out_tvalid, !in_tready,
                   "input taken while a region is pending")
  `IRTS_ASSERT_NOW(a_div_start_free, div_start, !div_stat.busy,
                   "divider restarted while busy")
  `IRTS_ASSERT_NEXT(a_accept_starts_div, in_tvalid && in_tready,
                    state_r == S_DH && div_stat.busy,
                    "accepted item did not start the height division")
  `IRTS_ASSERT_NOW(a_done_in_wait_state, div_stat.done,
                   state_r == S_DH || state_r == S_DW || state_r == S_MH ||
                   state_r == S_MW || state_r == S_SH,
                   "divider finished outside a waiting state")

endmodule

// File: test/image_region_thread_split_checker.sv
`timescale 1ns / 100ps
// Scoreboard for image_region_thread_split: predicts each request's regions and checks output items.
module image_region_thread_split_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // thread_count, image_height, image_width, row_offset, col_offset,
  // row_stride, col_stride (lowest bits first), zero padded
  input  logic [63:0]                     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // top_row, left_col, row_count, col_count (lowest bits first), zero padded
  input  logic [irts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              regions_due
);
  localparam int FW          = irts_pkg::OUT_FIELD_W;
  localparam int MAX_THREADS = irts_pkg::DEF_MAX_THREADS;

  typedef struct packed {
    logic [3:0]  pad;
    logic [3:0]  col_stride;
    logic [3:0]  row_stride;
    logic [11:0] col_offset;
    logic [11:0] row_offset;
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [3:0]  thread_count;
  } request_t;

  typedef struct packed {
    logic          last_region;
    logic [FW-1:0] col_count;
    logic [FW-1:0] row_count;
    logic [FW-1:0] left_col;
    logic [FW-1:0] top_row;
  } region_t;

  region_t region_q[$];
  int      mismatches = 0;
  int      pending    = 0;

  assign fail_count  = mismatches;
  assign regions_due = pending;

  function automatic void predict_regions(request_t req);
    int unsigned threads, rstride, cstride, ah, aw, remain, share;
    int unsigned stride, size, offset, pos, n, i, k;
    int unsigned shares[MAX_THREADS];
    bit          by_height, odd;
    region_t     r;
    threads = req.thread_count;
    if (threads == 0) threads = 1;
    if (threads > MAX_THREADS) threads = MAX_THREADS;
    rstride = (req.row_stride == 0) ? 1 : req.row_stride;
    cstride = (req.col_stride == 0) ? 1 : req.col_stride;
    ah = req.image_height / rstride;
    aw = req.image_width / cstride;
    // height wins when it splits evenly, then width, then the strictly larger one
    if (ah % threads == 0) by_height = 1'b1;
    else if (aw % threads == 0) by_height = 1'b0;
    else by_height = (ah > aw);
    remain = by_height ? ah : aw;
    stride = by_height ? rstride : cstride;
    size   = by_height ? req.image_height : req.image_width;
    offset = by_height ? req.row_offset : req.col_offset;
    n = 0;
    for (i = threads; i > 0; i--) begin
      share  = (remain + i - 1) / i;
      remain -= share;
      if (share > 0) begin
        shares[n] = share * stride;
        n++;
      end
    end
    if (n == 0) return;
    odd = (size % 2) == 1;
    if (odd) shares[n-1] += 1;
    pos = 0;
    for (k = 0; k < n; k++) begin
      share = shares[k];
      if (odd && pos + offset + share > size) share -= 1;
      r.top_row     = by_height ? FW'(pos + offset) : '0;
      r.left_col    = by_height ? '0 : FW'(pos + offset);
      r.row_count   = by_height ? FW'(share) : FW'(req.image_height);
      r.col_count   = by_height ? FW'(req.image_width) : FW'(share);
      r.last_region = (k == n - 1);
      region_q = {region_q, r};
      pos += share;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    region_t got;
    region_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_regions(request_t'(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata[4*FW-1:0]};
        if (region_q.size() == 0) begin
          $error("region item with none expected: %p", got);
          mismatches++;
        end else begin
          want = region_q.pop_front();
          check_field("top_row", want.top_row, got.top_row);
          check_field("left_col", want.left_col, got.left_col);
          check_field("row_count", want.row_count, got.row_count);
          check_field("col_count", want.col_count, got.col_count);
          check_field("last_region", want.last_region, got.last_region);
        end
      end
      pending = region_q.size();
    end
  end

endmodule

// File: test/image_region_thread_split_tb.sv
`timescale 1ns / 100ps
// Top-level testbench for image_region_thread_split: clock, reset, requests and verdict.
module image_region_thread_split_tb;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [63:0]                     in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [irts_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;
  int                              fail_count;
  int                              regions_due;

  int phase       = 0;
  int tx_idle_pct = 16;
  int rx_idle_pct = 46;

  image_region_thread_split dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  image_region_thread_split_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .regions_due (regions_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off when the no-idle phase starts
  initial begin
    int hold_left;
    bit held;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [3:0] threads, input logic [11:0] height,
                              input logic [11:0] width, input logic [11:0] row_off,
                              input logic [11:0] col_off, input logic [3:0] row_str,
                              input logic [3:0] col_str);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, col_str, row_str, col_off, row_off, width, height, threads};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly in range; now and then zero or above the thread limit
  function automatic logic [3:0] pick_threads();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  function automatic logic [11:0] pick_dim();
    if ($urandom_range(0, 7) == 0) return 12'($urandom_range(0, 20));
    return 12'($urandom_range(1, 4095));
  endfunction

  function automatic logic [3:0] pick_stride();
    if ($urandom_range(0, 15) == 0) return 4'd0;
    return 4'($urandom_range(1, 15));
  endfunction

  initial begin
    int n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    send_request(1, 1, 1, 0, 0, 1, 1);
    send_request(8, 4095, 4095, 4095, 4095, 1, 1);    // tie, width taken
    send_request(0, 100, 50, 3, 7, 1, 1);             // zero threads
    send_request(15, 64, 30, 0, 0, 1, 1);             // thread count saturates
    send_request(4, 40, 40, 10, 20, 0, 0);            // zero strides
    send_request(8, 4095, 4095, 0, 0, 15, 15);
    send_request(3, 0, 0, 0, 0, 1, 1);                // nothing to split
    send_request(5, 7, 9, 0, 0, 15, 1);               // height below stride: empty
    send_request(8, 3, 5, 1, 2, 1, 1);                // zero shares dropped
    send_request(3, 13, 8, 1, 0, 2, 1);               // odd height, last share trimmed
    send_request(8, 9, 1, 100, 0, 1, 1);              // uneven shares, the first one larger
    send_request(6, 10, 12, 5, 6, 1, 1);              // width splits evenly
    send_request(7, 14, 7, 0, 0, 1, 1);
    send_request(2, 4094, 4095, 4095, 4095, 1, 1);
    send_request(8, 4095, 1, 0, 4095, 1, 1);
    send_request(8, 1, 4095, 0, 4095, 1, 15);
    send_request(9, 30, 31, 0, 0, 3, 0);
    send_request(1, 4095, 4095, 4095, 0, 15, 15);
    send_request(5, 0, 100, 0, 0, 1, 1);
    send_request(4, 100, 0, 0, 0, 1, 1);

    for (n = 0; n < 200; n++) begin
      if (n == 67) begin
        tx_idle_pct = 46;
        rx_idle_pct = 16;
        phase       = 1;
      end
      if (n == 134) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase       = 2;
      end
      send_request(pick_threads(), pick_dim(), pick_dim(), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), pick_stride(), pick_stride());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (regions_due != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
